### hdl/nary_integer_alu_accumulator_top_macros.svh
// assertion helpers shared by the asserting modules
`ifndef NARY_INTEGER_ALU_ACCUMULATOR_TOP_MACROS_SVH
`define NARY_INTEGER_ALU_ACCUMULATOR_TOP_MACROS_SVH

// checked outside reset
`define NAIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define NAIA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/naia_pkg.sv
// ----------------------------------------------------------------------------
// naia_pkg
// types and codes shared by the n-ary integer alu files
// ----------------------------------------------------------------------------
package naia_pkg;

  // commands
  localparam logic [3:0] CMD_RESET = 4'd0;
  localparam logic [3:0] CMD_LOAD  = 4'd1;
  localparam logic [3:0] CMD_PUSH  = 4'd2;
  localparam logic [3:0] CMD_POP   = 4'd3;
  localparam logic [3:0] CMD_PEEK  = 4'd4;
  localparam logic [3:0] CMD_CLEAR = 4'd5;
  localparam logic [3:0] CMD_NARY  = 4'd6;
  localparam logic [3:0] CMD_FIRST = 4'd7;
  localparam logic [3:0] CMD_NEXT  = 4'd8;
  localparam logic [3:0] CMD_UNARY = 4'd9;

  // n-ary selectors
  localparam logic [3:0] NS_ADD    = 4'd0;
  localparam logic [3:0] NS_ADDSQR = 4'd1;
  localparam logic [3:0] NS_MUL    = 4'd2;
  localparam logic [3:0] NS_LAND   = 4'd3;
  localparam logic [3:0] NS_LOR    = 4'd4;
  localparam logic [3:0] NS_LXOR   = 4'd5;
  localparam logic [3:0] NS_BAND   = 4'd6;
  localparam logic [3:0] NS_BOR    = 4'd7;
  localparam logic [3:0] NS_BXOR   = 4'd8;

  // first/next selectors
  localparam logic [3:0] FS_SUB = 4'd0;
  localparam logic [3:0] FS_DIV = 4'd1;
  localparam logic [3:0] FS_POW = 4'd2;

  // unary selectors
  localparam logic [3:0] US_SQR  = 4'd0;
  localparam logic [3:0] US_ABS  = 4'd1;
  localparam logic [3:0] US_NOT  = 4'd2;
  localparam logic [3:0] US_BNOT = 4'd3;
  localparam logic [3:0] US_NEG  = 4'd4;

  // operation codes kept for chaining
  localparam logic [3:0] OPC_NARY_BASE = 4'd1;
  localparam logic [3:0] OPC_FAM_BASE  = 4'd10;

  // status
  localparam logic [1:0] STAT_COLLECT = 2'd0;
  localparam logic [1:0] STAT_READY   = 2'd1;
  localparam logic [1:0] STAT_ERROR   = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_FMT   = 3'd1;
  localparam logic [2:0] ERR_OVF   = 3'd2;
  localparam logic [2:0] ERR_DIV0  = 3'd3;
  localparam logic [2:0] ERR_EMPTY = 3'd4;
  localparam logic [2:0] ERR_FULL  = 3'd5;

  // configuration register indexes
  localparam int         CFG_IDX_W     = 2;
  localparam logic [1:0] CFG_OPCOUNT   = 2'd0;
  localparam logic [1:0] CFG_ENABLE    = 2'd1;

  localparam logic [3:0]  TALLY_MAX = 4'd15;
  localparam logic [31:0] INT_MIN_C = 32'h8000_0000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_SREAD, ST_CRD, ST_CLD, ST_EXE,
    ST_MUL, ST_MCHK, ST_DIV, ST_POW, ST_FIN
  } naia_state_t;

  typedef enum logic [1:0] {
    K_NARY, K_FAM, K_UN
  } naia_kind_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

endpackage

### hdl/nary_integer_alu_accumulator_top.sv
// ----------------------------------------------------------------------------
// nary_integer_alu_accumulator_top
// n-ary integer alu: operands held in a ram, folded by a sequencer, plus a
// result stack in a second ram
// ----------------------------------------------------------------------------
// a simple request passes accept, decode and output; pop/peek add a stack read
// computation: a read and load per operand, an execute per non-power step, then
//   a divider wait per divide, multiply and check per multiply step or power round
// throughput: one request in flight; the next is taken while the result waits
//   in the output register
// reset: synchronous, no clearing pass; the rams are not cleared
module nary_integer_alu_accumulator_top #(
  parameter int OPERAND_DEPTH = 8,
  parameter int STACK_DEPTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     command,
  input  logic [3:0]                     op_select,
  input  logic signed [31:0]             operand_value,
  input  logic                           value_present,
  input  logic                           value_is_number,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             result_value,
  output logic signed [31:0]             read_data,
  output logic                           read_valid,
  output logic [1:0]                     ready_status,
  output logic                           result_done,
  output logic                           zero_flag,
  output logic                           negative_flag,
  output logic                           positive_flag,
  output logic [2:0]                     error_code,
  // configuration
  input  logic                           cfg_write_en,
  input  logic [naia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [3:0]                     cfg_write_data
);
  import naia_pkg::*;

  `include "nary_integer_alu_accumulator_top_macros.svh"

  localparam int OAW = $clog2(OPERAND_DEPTH);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SCW = $clog2(STACK_DEPTH + 1);

  function automatic logic fits32(input logic [63:0] v);
    return (v[63:31] == '0) || (v[63:31] == '1);
  endfunction

  naia_state_t state, state_next;

  // latched request
  logic [3:0]  cmd_q, sel_q;
  logic [31:0] v_q;
  logic        pres_q, num_q;

  // architectural state
  logic signed [31:0] result_reg;
  logic [3:0]         tally;
  logic               valid0;
  logic [3:0]         cur_op;
  logic [1:0]         status;
  logic [SCW-1:0]     stk_cnt;
  logic [3:0]         opcnt;
  logic               enabled;

  // sequencer datapath
  logic [4:0]         idx;
  logic signed [31:0] r_q, x_q, mul_a, mul_b;
  logic signed [63:0] prod_q;
  logic [30:0]        cnt_q;
  naia_kind_t         knd;
  logic               done_q, rv_q;
  logic [2:0]         err_q;
  logic [31:0]        rd_q;

  // output register
  logic signed [31:0] o_result, o_rd;
  logic               o_rv, o_done;
  logic [1:0]         o_stat;
  logic [2:0]         o_err;

  // rams
  logic               opr_we, stk_we;
  logic [OAW-1:0]     opr_waddr;
  logic [31:0]        opr_rdata, stk_rdata;
  logic [SCW-1:0]     stk_top;
  div_req_t           div_req;
  logic [31:0]        div_quot;
  logic               div_done;

  // effective operand count, clamped to 1..depth
  logic [4:0] n_eff;
  always_comb begin
    if (opcnt == 4'd0) begin
      n_eff = 5'd1;
    end else if ({1'b0, opcnt} > 5'(OPERAND_DEPTH)) begin
      n_eff = 5'(OPERAND_DEPTH);
    end else begin
      n_eff = {1'b0, opcnt};
    end
  end

  // decode of the latched request
  logic       fmt_err, is_nary, is_fam, is_un, clr, v0, valid0_new, trig, wr_ok;
  logic       stk_full, stk_empty;
  logic [3:0] new_op, t0, t0_inc, tally_new;
  logic [4:0] wr_idx;
  always_comb begin
    fmt_err = pres_q && !num_q && ((cmd_q == CMD_LOAD) || (cmd_q == CMD_PUSH) ||
              ((cmd_q >= CMD_NARY) && (cmd_q <= CMD_UNARY)));
    is_nary = (cmd_q == CMD_NARY) && (sel_q <= NS_BXOR);
    is_fam  = ((cmd_q == CMD_FIRST) || (cmd_q == CMD_NEXT)) && (sel_q <= FS_POW);
    is_un   = (cmd_q == CMD_UNARY) && (sel_q <= US_NEG);
    new_op  = is_nary ? (sel_q + OPC_NARY_BASE) : (sel_q + OPC_FAM_BASE);
    clr     = (status != STAT_COLLECT) || (cur_op != new_op);
    t0      = clr ? 4'd0 : tally;
    v0      = clr ? 1'b0 : valid0;
    t0_inc  = (t0 == TALLY_MAX) ? TALLY_MAX : (t0 + 4'd1);
    if (is_nary) begin
      wr_idx = {1'b0, t0};
    end else if (cmd_q == CMD_FIRST) begin
      wr_idx = 5'd0;
    end else begin
      wr_idx = {1'b0, t0} + {4'd0, !v0};
    end
    wr_ok      = wr_idx < 5'(OPERAND_DEPTH);
    tally_new  = ((cmd_q == CMD_FIRST) && v0) ? t0 : t0_inc;
    valid0_new = v0 || (cmd_q == CMD_FIRST) || (is_nary && (t0 == 4'd0));
    trig       = ({1'b0, tally_new} >= n_eff) && (is_nary || valid0_new);
    stk_full   = stk_cnt == SCW'(STACK_DEPTH);
    stk_empty  = stk_cnt == '0;
    stk_top    = stk_cnt - SCW'(1);
  end

  // unary results other than square
  logic [31:0] ut;
  logic        ufail;
  always_comb begin
    ufail = 1'b0;
    case (sel_q)
      US_ABS: begin
        ut    = v_q[31] ? (~v_q + 32'd1) : v_q;
        ufail = v_q == INT_MIN_C;
      end
      US_NOT:  ut = {31'd0, v_q == 32'd0};
      US_BNOT: ut = ~v_q;
      default: begin
        ut    = ~v_q + 32'd1;
        ufail = v_q == INT_MIN_C;
      end
    endcase
  end

  // one fold step without multiplier or divider
  logic [63:0] et, r64, x64;
  logic        step_mul, step_div, more, div_ovf;
  always_comb begin
    r64      = {{32{r_q[31]}}, r_q};
    x64      = {{32{x_q[31]}}, x_q};
    step_mul = (knd == K_NARY) && ((sel_q == NS_ADDSQR) || (sel_q == NS_MUL));
    step_div = (knd == K_FAM) && (sel_q == FS_DIV);
    div_ovf  = (r_q == INT_MIN_C) && (x_q == '1);
    more     = (idx + 5'd1) < n_eff;
    if (knd == K_FAM) begin
      et = r64 - x64;
    end else begin
      case (sel_q)
        NS_ADD:  et = r64 + x64;
        NS_LAND: et = {63'd0, (r_q != 0) && (x_q != 0)};
        NS_LOR:  et = {63'd0, (r_q != 0) || (x_q != 0)};
        NS_LXOR: et = {63'd0, (r_q != 0) != (x_q != 0)};
        NS_BAND: et = r64 & x64;
        NS_BOR:  et = r64 | x64;
        default: et = r64 ^ x64;
      endcase
    end
  end

  // multiplier check: sum of squares adds the running value after the first
  logic [63:0] mt;
  assign mt = ((knd == K_NARY) && (sel_q == NS_ADDSQR) && (idx != 5'd0)) ?
              (prod_q + r64) : prod_q;

  // power of a special base, or a zero exponent
  logic        pow_loop, pow_fail;
  logic [31:0] pv;
  always_comb begin
    pow_fail = x_q[31] && (r_q == 0);
    pow_loop = !x_q[31] && (x_q != 0) && (r_q != 0) && (r_q != 1) && (r_q != -1);
    if (r_q == 1) begin
      pv = 32'd1;
    end else if (r_q == -1) begin
      pv = x_q[0] ? '1 : 32'd1;
    end else if (r_q == 0) begin
      pv = {31'd0, x_q == 0};
    end else begin
      pv = x_q[31] ? 32'd0 : 32'd1;
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        state_next = ST_FIN;
        if (enabled && !fmt_err) begin
          case (cmd_q)
            CMD_POP, CMD_PEEK: if (!stk_empty) state_next = ST_SREAD;
            CMD_NARY, CMD_FIRST, CMD_NEXT:
              if ((is_nary || is_fam) && trig) state_next = ST_CRD;
            CMD_UNARY: if (is_un && (sel_q == US_SQR)) state_next = ST_MUL;
            default: state_next = ST_FIN;
          endcase
        end
      end
      ST_SREAD: state_next = ST_FIN;
      ST_CRD:   state_next = ST_CLD;
      ST_CLD: begin
        if (idx == 5'd0) begin
          if ((knd == K_NARY) && (sel_q == NS_ADDSQR)) state_next = ST_MUL;
          else state_next = more ? ST_CRD : ST_FIN;
        end else if ((knd == K_FAM) && (sel_q == FS_POW)) begin
          state_next = ST_POW;
        end else begin
          state_next = ST_EXE;
        end
      end
      ST_EXE: begin
        if (step_mul) state_next = ST_MUL;
        else if (step_div) state_next = ((x_q == 0) || div_ovf) ? ST_FIN : ST_DIV;
        else if (!fits32(et)) state_next = ST_FIN;
        else state_next = more ? ST_CRD : ST_FIN;
      end
      ST_MUL: state_next = ST_MCHK;
      ST_MCHK: begin
        if (!fits32(mt) || (knd == K_UN)) state_next = ST_FIN;
        else if (knd == K_FAM) state_next = (cnt_q == 31'd1) ? ST_FIN : ST_MUL;
        else state_next = more ? ST_CRD : ST_FIN;
      end
      ST_DIV: if (div_done) state_next = more ? ST_CRD : ST_FIN;
      ST_POW: state_next = (!pow_fail && pow_loop) ? ST_MUL : ST_FIN;
      ST_FIN: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready         = state == ST_IDLE;
    opr_we           = 1'b0;
    opr_waddr        = '0;
    stk_we           = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = r_q;
    div_req.divisor  = x_q;
    unique case (state)
      ST_DECODE: begin
        if (enabled && !fmt_err) begin
          opr_we    = is_un || ((is_nary || is_fam) && wr_ok);
          opr_waddr = is_un ? '0 : wr_idx[OAW-1:0];
          stk_we    = (cmd_q == CMD_PUSH) && !stk_full;
        end
      end
      ST_EXE: div_req.start = step_div && (x_q != 0) && !div_ovf;
      default: ;
    endcase
  end

  // datapath and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      result_reg <= '0;
      tally      <= '0;
      valid0     <= 1'b0;
      cur_op     <= '0;
      status     <= STAT_COLLECT;
      stk_cnt    <= '0;
      opcnt      <= 4'd2;
      enabled    <= 1'b1;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        if (cfg_index == CFG_OPCOUNT) opcnt <= cfg_write_data;
        else if (cfg_index == CFG_ENABLE) enabled <= cfg_write_data[0];
      end
      // result register loads on leaving fin, empties when taken
      if ((state == ST_FIN) && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cmd_q  <= command;
            sel_q  <= op_select;
            v_q    <= value_present ? operand_value : result_reg;
            pres_q <= value_present;
            num_q  <= value_is_number;
            done_q <= 1'b0;
            err_q  <= ERR_NONE;
            rv_q   <= 1'b0;
            rd_q   <= '0;
          end
        end
        ST_DECODE: begin
          if (enabled) begin
            if (fmt_err) begin
              status <= STAT_ERROR;
              err_q  <= ERR_FMT;
            end else begin
              case (cmd_q)
                CMD_RESET: begin
                  result_reg <= '0;
                  tally      <= '0;
                  valid0     <= 1'b0;
                  status     <= STAT_COLLECT;
                  stk_cnt    <= '0;
                end
                CMD_LOAD: result_reg <= v_q;
                CMD_PUSH: begin
                  if (stk_full) err_q <= ERR_FULL;
                  else stk_cnt <= stk_cnt + SCW'(1);
                end
                CMD_POP, CMD_PEEK: if (stk_empty) err_q <= ERR_EMPTY;
                CMD_CLEAR: begin
                  tally  <= '0;
                  valid0 <= 1'b0;
                end
                CMD_NARY, CMD_FIRST, CMD_NEXT: begin
                  if (is_nary || is_fam) begin
                    cur_op <= new_op;
                    if (clr) status <= STAT_COLLECT;
                    tally  <= tally_new;
                    valid0 <= valid0_new;
                    knd    <= is_nary ? K_NARY : K_FAM;
                    idx    <= '0;
                    if (trig) done_q <= 1'b1;
                  end
                end
                CMD_UNARY: begin
                  if (is_un) begin
                    tally  <= 4'd1;
                    valid0 <= 1'b1;
                    done_q <= 1'b1;
                    knd    <= K_UN;
                    mul_a  <= v_q;
                    mul_b  <= v_q;
                    if (sel_q == US_SQR) begin
                      result_reg <= v_q;
                    end else if (ufail) begin
                      result_reg <= v_q;
                      status     <= STAT_ERROR;
                      err_q      <= ERR_OVF;
                    end else begin
                      result_reg <= ut;
                      if (status != STAT_ERROR) status <= STAT_READY;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
        ST_SREAD: begin
          rd_q <= stk_rdata;
          rv_q <= 1'b1;
          if (!pres_q) result_reg <= stk_rdata;
          if (cmd_q == CMD_POP) stk_cnt <= stk_cnt - SCW'(1);
        end
        ST_CLD: begin
          x_q <= opr_rdata;
          if (idx == 5'd0) begin
            r_q        <= opr_rdata;
            result_reg <= opr_rdata;
            mul_a      <= opr_rdata;
            mul_b      <= opr_rdata;
            if (!((knd == K_NARY) && (sel_q == NS_ADDSQR))) begin
              if (more) idx <= idx + 5'd1;
              else status <= STAT_READY;
            end
          end
        end
        ST_EXE: begin
          if (step_mul) begin
            mul_a <= (sel_q == NS_MUL) ? r_q : x_q;
            mul_b <= x_q;
          end else if (step_div) begin
            if (x_q == 0) begin
              status <= STAT_ERROR;
              err_q  <= ERR_DIV0;
            end else if (div_ovf) begin
              status <= STAT_ERROR;
              err_q  <= ERR_OVF;
            end
          end else if (!fits32(et)) begin
            status <= STAT_ERROR;
            err_q  <= ERR_OVF;
          end else begin
            r_q        <= et[31:0];
            result_reg <= et[31:0];
            if (more) idx <= idx + 5'd1;
            else status <= STAT_READY;
          end
        end
        ST_MUL: prod_q <= mul_a * mul_b;
        ST_MCHK: begin
          if (!fits32(mt)) begin
            status <= STAT_ERROR;
            err_q  <= ERR_OVF;
          end else begin
            case (knd)
              K_UN: begin
                result_reg <= mt[31:0];
                if (status != STAT_ERROR) status <= STAT_READY;
              end
              K_FAM: begin
                if (cnt_q == 31'd1) begin
                  result_reg <= mt[31:0];
                  status     <= STAT_READY;
                end else begin
                  mul_a <= mt[31:0];
                  cnt_q <= cnt_q - 31'd1;
                end
              end
              default: begin
                r_q        <= mt[31:0];
                result_reg <= mt[31:0];
                if (more) idx <= idx + 5'd1;
                else status <= STAT_READY;
              end
            endcase
          end
        end
        ST_DIV: begin
          if (div_done) begin
            r_q        <= div_quot;
            result_reg <= div_quot;
            if (more) idx <= idx + 5'd1;
            else status <= STAT_READY;
          end
        end
        ST_POW: begin
          if (pow_fail) begin
            status <= STAT_ERROR;
            err_q  <= ERR_DIV0;
          end else if (pow_loop) begin
            mul_a <= 32'sd1;
            mul_b <= r_q;
            cnt_q <= x_q[30:0];
          end else begin
            result_reg <= pv;
            status     <= STAT_READY;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            o_result  <= result_reg;
            o_rd      <= rd_q;
            o_rv      <= rv_q;
            o_stat    <= status;
            o_done    <= done_q;
            o_err     <= err_q;
          end
        end
        default: ;
      endcase
    end
  end

  // operand store
  naia_ram #(.WIDTH(32), .DEPTH(OPERAND_DEPTH)) u_opr_ram (
    .clk   (clk),
    .we    (opr_we),
    .waddr (opr_waddr),
    .wdata (v_q),
    .raddr (idx[OAW-1:0]),
    .rdata (opr_rdata)
  );

  // result stack
  naia_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_cnt[SAW-1:0]),
    .wdata (v_q),
    .raddr (stk_top[SAW-1:0]),
    .rdata (stk_rdata)
  );

  naia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .div_req  (div_req),
    .quotient (div_quot),
    .done     (div_done)
  );

  assign result_value  = o_result;
  assign read_data     = o_rd;
  assign read_valid    = o_rv;
  assign ready_status  = o_stat;
  assign result_done   = o_done;
  assign error_code    = o_err;
  assign zero_flag     = o_result == 0;
  assign negative_flag = o_result[31];
  assign positive_flag = !o_result[31] && (o_result != 0);

  `NAIA_ASSERT(a_accept_decode, (in_valid && in_ready) |=> (state == ST_DECODE), "request not decoded")
  `NAIA_ASSERT(a_div_leave, (state == ST_DIV && div_done) |=> (state != ST_DIV), "divide wait stuck")
  `NAIA_ASSERT(a_stack_bound, (stk_cnt <= SCW'(STACK_DEPTH)), "stack count beyond depth")
  `NAIA_ASSERT_ALWAYS(a_reset, rst |=> ((state == ST_IDLE) && (stk_cnt == '0) && !out_valid), "reset state wrong")

endmodule

### hdl/naia_ram.sv
// ----------------------------------------------------------------------------
// naia_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module naia_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 16,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/naia_div.sv
// ----------------------------------------------------------------------------
// naia_div
// signed 32-bit divider, one quotient bit per cycle, truncating
// ----------------------------------------------------------------------------
module naia_div (
  input  logic               clk,
  input  logic               rst,
  input  naia_pkg::div_req_t div_req,
  output logic [31:0]        quotient,
  output logic               done
);
  import naia_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] den;
  logic        neg;
  logic [32:0] shifted;
  logic [33:0] diff;

  assign shifted  = {rem, quo[31]};
  assign diff     = {1'b0, shifted} - {2'b00, den};
  assign quotient = neg ? (~quo + 32'd1) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd31;
        rem  <= '0;
        quo  <= div_req.dividend[31] ? (~div_req.dividend + 32'd1) : div_req.dividend;
        den  <= div_req.divisor[31] ? (~div_req.divisor + 32'd1) : div_req.divisor;
        neg  <= div_req.dividend[31] ^ div_req.divisor[31];
      end else if (busy) begin
        if (!diff[33]) begin
          rem <= diff[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= shifted[31:0];
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
